// ===== rtl/estl_pkg.sv =====
// Shared types and constants for the event sequence table loader.
`default_nettype none
package estl_pkg;

	localparam int unsigned RAM_ADDR_WIDTH_DEF = 11;
	localparam logic [23:0] ESCAPE_GAP_DEF     = 24'hFF_FFFF;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned PKT_W   = 16;
	localparam int unsigned ADDR_W  = 12;
	localparam int unsigned GAP_W   = 28;
	localparam int unsigned EVENT_W = 8;

	localparam logic [WORD_W-1:0]  GAP_MAX        = 32'h0FFF_FFFF;
	localparam logic [EVENT_W-1:0] END_CODE_RESET = 8'd127;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_ENTRY   = 2'd0,
		KIND_DISABLE = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	// one classified sequence word
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              first;
		logic              last;
		logic              pk_zero;
		logic [PKT_W-1:0]  pk;
		logic              sel;
		logic              esc_match;
	} word_rec_t;

	typedef struct packed {
		logic      valid;
		word_rec_t rec;
	} q_head_t;

endpackage
`default_nettype wire

// ===== rtl/estl_front.sv =====
// Front end: takes input requests and classifies each sequence word.
`default_nettype none
module estl_front
	import estl_pkg::*;
#(
	parameter logic [23:0] ESCAPE_GAP = ESCAPE_GAP_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [WORD_W-1:0] seq_word,
	input  wire logic              first_word,
	input  wire logic              last_word,
	input  wire logic [PKT_W-1:0]  packet_number,
	input  wire logic              sequence_select,
	input  wire logic              q_full,
	output logic                   q_push,
	output word_rec_t              q_push_rec
);

	logic      valid_s1;
	word_rec_t rec_s1;
	logic      accept;

	assign q_push     = valid_s1 && !q_full;
	assign in_stall   = valid_s1 && q_full;
	assign accept     = in_valid && !in_stall;
	assign q_push_rec = rec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !q_push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1.word      <= seq_word;
			rec_s1.first     <= first_word;
			rec_s1.last      <= last_word;
			rec_s1.pk_zero   <= (packet_number == '0);
			rec_s1.pk        <= packet_number;
			rec_s1.sel       <= sequence_select;
			rec_s1.esc_match <= (seq_word[WORD_W-1:EVENT_W] == ESCAPE_GAP);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/estl_queue.sv =====
// Short queue of classified words between front and back end.
`default_nettype none
module estl_queue
	import estl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  word_rec_t      push_rec,
	output logic           full,
	input  wire logic      pop,
	output q_head_t        head
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	word_rec_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.rec   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/estl_back.sv =====
// Back end: load state, filler splitting and result output register.
`default_nettype none
module estl_back
	import estl_pkg::*;
#(
	parameter int unsigned RAM_ADDR_WIDTH = RAM_ADDR_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [EVENT_W-1:0] end_code,
	input  q_head_t                 head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              result_kind,
	output logic [ADDR_W-1:0]       ram_address,
	output logic [GAP_W-1:0]        entry_gap,
	output logic [EVENT_W-1:0]      entry_event,
	output logic                    packet_ok,
	output logic                    table_valid,
	output logic                    last_result
);

	localparam int unsigned CW = RAM_ADDR_WIDTH + 1;
	localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(1 << RAM_ADDR_WIDTH);

	typedef enum logic [3:0] {
		BK_EVAL = 4'b0001,
		BK_EMIT = 4'b0010,
		BK_STAT = 4'b0100,
		BK_FAIL = 4'b1000
	} bk_state_t;

	bk_state_t          state_q, state_n;
	logic               loading_q, loading_n;
	logic               valid_q, valid_n;
	logic [PKT_W-1:0]   exp_q, exp_n;
	logic [CW-1:0]      ent_q, ent_n;
	logic               esc_q, esc_n;
	logic [EVENT_W-1:0] pend_q, pend_n;
	logic               skip_q, skip_n;
	logic [ADDR_W-1:0]  base_q, base_n;
	logic [WORD_W-1:0]  gap_q, gap_n;
	logic [EVENT_W-1:0] ev_q, ev_n;
	logic               lastw_q, lastw_n;

	logic               ov_q;
	kind_t              kind_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [GAP_W-1:0]   rgap_q;
	logic [EVENT_W-1:0] rev_q;
	logic               ok_q, tv_q, rlast_q;

	logic               e_valid;
	kind_t              e_kind;
	logic [ADDR_W-1:0]  e_addr;
	logic [GAP_W-1:0]   e_gap;
	logic [EVENT_W-1:0] e_ev;
	logic               e_ok, e_tv, e_last;

	logic               slot_free;
	logic [31:0]        ent_ext;
	logic [ADDR_W-1:0]  base_new;
	word_rec_t          cur;

	assign slot_free = !ov_q || !out_stall;
	assign ent_ext   = 32'(ent_q);
	assign cur       = head.rec;
	assign base_new  = cur.sel ? BASE_STEP : '0;

	always_comb begin
		logic hdr;
		logic word_go;
		logic eff_esc;

		hdr       = 1'b0;
		word_go   = 1'b0;
		eff_esc   = cur.first ? 1'b0 : esc_q;
		state_n   = state_q;
		loading_n = loading_q;
		valid_n   = valid_q;
		exp_n     = exp_q;
		ent_n     = ent_q;
		esc_n     = esc_q;
		pend_n    = pend_q;
		skip_n    = skip_q;
		base_n    = base_q;
		gap_n     = gap_q;
		ev_n      = ev_q;
		lastw_n   = lastw_q;
		pop       = 1'b0;
		e_valid   = 1'b0;
		e_kind    = KIND_ENTRY;
		e_addr    = '0;
		e_gap     = '0;
		e_ev      = '0;
		e_ok      = 1'b0;
		e_tv      = valid_q;
		e_last    = 1'b0;

		unique case (state_q)
			BK_EVAL: begin
				if (head.valid && slot_free) begin
					pop = 1'b1;
					if (cur.first) begin
						skip_n = 1'b0;
						esc_n  = 1'b0;
					end
					if (cur.first && cur.pk_zero) begin
						// restart: disable the sequence, then handle the word
						hdr       = 1'b1;
						word_go   = 1'b1;
						base_n    = base_new;
						loading_n = 1'b1;
						valid_n   = 1'b0;
						exp_n     = '0;
						ent_n     = '0;
						e_valid   = 1'b1;
						e_kind    = KIND_DISABLE;
						e_addr    = base_new;
						e_tv      = 1'b0;
						e_last    = cur.esc_match && !cur.last;
					end else if (cur.first && (!loading_q || cur.pk != exp_q)) begin
						skip_n  = 1'b1;
						esc_n   = 1'b0;
						e_valid = 1'b1;
						e_kind  = KIND_STATUS;
						e_last  = 1'b1;
					end else if (!cur.first && (skip_q || !loading_q)) begin
						word_go = 1'b0;
					end else begin
						word_go = 1'b1;
					end

					if (word_go) begin
						if (eff_esc) begin
							gap_n   = cur.word;
							ev_n    = pend_q;
							esc_n   = 1'b0;
							lastw_n = cur.last;
							state_n = BK_EMIT;
						end else if (cur.esc_match) begin
							if (!cur.last) begin
								esc_n  = 1'b1;
								pend_n = cur.word[EVENT_W-1:0];
							end else if (hdr) begin
								state_n = BK_FAIL;
							end else begin
								// escape word may not end a packet
								skip_n  = 1'b1;
								esc_n   = 1'b0;
								e_valid = 1'b1;
								e_kind  = KIND_STATUS;
								e_last  = 1'b1;
							end
						end else begin
							gap_n   = {{EVENT_W{1'b0}}, cur.word[WORD_W-1:EVENT_W]};
							ev_n    = cur.word[EVENT_W-1:0];
							lastw_n = cur.last;
							state_n = BK_EMIT;
						end
					end
				end
			end
			BK_EMIT: begin
				if (slot_free) begin
					e_valid = 1'b1;
					if (ent_q[CW-1]) begin
						// table region full
						skip_n  = 1'b1;
						esc_n   = 1'b0;
						e_kind  = KIND_STATUS;
						e_last  = 1'b1;
						state_n = BK_EVAL;
					end else if (gap_q > GAP_MAX) begin
						e_kind = KIND_ENTRY;
						e_addr = base_q + ent_ext[ADDR_W-1:0];
						e_gap  = GAP_MAX[GAP_W-1:0];
						gap_n  = gap_q - GAP_MAX;
						ent_n  = ent_q + CW'(1);
					end else begin
						e_kind = KIND_ENTRY;
						e_addr = base_q + ent_ext[ADDR_W-1:0];
						e_gap  = gap_q[GAP_W-1:0];
						e_ev   = ev_q;
						ent_n  = ent_q + CW'(1);
						if (ev_q == end_code) begin
							loading_n = 1'b0;
							valid_n   = 1'b1;
							skip_n    = 1'b1;
							state_n   = BK_STAT;
						end else if (lastw_q) begin
							exp_n   = exp_q + PKT_W'(1);
							state_n = BK_STAT;
						end else begin
							e_last  = 1'b1;
							state_n = BK_EVAL;
						end
					end
				end
			end
			BK_STAT: begin
				if (slot_free) begin
					e_valid = 1'b1;
					e_kind  = KIND_STATUS;
					e_ok    = 1'b1;
					e_last  = 1'b1;
					state_n = BK_EVAL;
				end
			end
			BK_FAIL: begin
				if (slot_free) begin
					skip_n  = 1'b1;
					esc_n   = 1'b0;
					e_valid = 1'b1;
					e_kind  = KIND_STATUS;
					e_last  = 1'b1;
					state_n = BK_EVAL;
				end
			end
			default: begin
				state_n = BK_EVAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_EVAL;
			loading_q <= 1'b0;
			valid_q   <= 1'b0;
			exp_q     <= '0;
			ent_q     <= '0;
			esc_q     <= 1'b0;
			pend_q    <= '0;
			skip_q    <= 1'b0;
			base_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_n;
			loading_q <= loading_n;
			valid_q   <= valid_n;
			exp_q     <= exp_n;
			ent_q     <= ent_n;
			esc_q     <= esc_n;
			pend_q    <= pend_n;
			skip_q    <= skip_n;
			base_q    <= base_n;
			if (slot_free) begin
				ov_q <= e_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		gap_q   <= gap_n;
		ev_q    <= ev_n;
		lastw_q <= lastw_n;
		if (e_valid) begin
			kind_q  <= e_kind;
			addr_q  <= e_addr;
			rgap_q  <= e_gap;
			rev_q   <= e_ev;
			ok_q    <= e_ok;
			tv_q    <= e_tv;
			rlast_q <= e_last;
		end
	end

	assign out_valid   = ov_q;
	assign result_kind = kind_q;
	assign ram_address = addr_q;
	assign entry_gap   = rgap_q;
	assign entry_event = rev_q;
	assign packet_ok   = ok_q;
	assign table_valid = tv_q;
	assign last_result = rlast_q;

endmodule
`default_nettype wire

// ===== rtl/event_sequence_table_loader.sv =====
// A disable result, or a status result decided in BK_EVAL, passes the front register,
// the queue and the back end's output register; a RAM entry result also passes BK_EMIT.
// Back end: a word without entries ends in BK_EVAL; else it emits each RAM entry result
// (fillers included) from BK_EMIT, then any status, and takes no new word meanwhile.
// A 2-deep queue lets the input side take new requests while results are stalled.
// Reset (arst_n low, async): load state and queues cleared, end event code = 127.
`default_nettype none
module event_sequence_table_loader
	import estl_pkg::*;
#(
	parameter int unsigned RAM_ADDR_WIDTH = RAM_ADDR_WIDTH_DEF,
	parameter logic [23:0] ESCAPE_GAP     = ESCAPE_GAP_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [EVENT_W-1:0] cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [WORD_W-1:0]  seq_word,
	input  wire logic               first_word,
	input  wire logic               last_word,
	input  wire logic [PKT_W-1:0]   packet_number,
	input  wire logic               sequence_select,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              result_kind,
	output logic [ADDR_W-1:0]       ram_address,
	output logic [GAP_W-1:0]        entry_gap,
	output logic [EVENT_W-1:0]      entry_event,
	output logic                    packet_ok,
	output logic                    table_valid,
	output logic                    last_result
);

	logic [EVENT_W-1:0] end_code_q;
	logic               q_full;
	logic               q_push;
	word_rec_t          q_push_rec;
	logic               q_pop;
	q_head_t            q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q <= END_CODE_RESET;
		end else if (cfg_wr_en) begin
			end_code_q <= cfg_wr_data;
		end
	end

	estl_front #(
		.ESCAPE_GAP (ESCAPE_GAP)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.seq_word        (seq_word),
		.first_word      (first_word),
		.last_word       (last_word),
		.packet_number   (packet_number),
		.sequence_select (sequence_select),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_push_rec      (q_push_rec)
	);

	estl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	estl_back #(
		.RAM_ADDR_WIDTH (RAM_ADDR_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.end_code    (end_code_q),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.ram_address (ram_address),
		.entry_gap   (entry_gap),
		.entry_event (entry_event),
		.packet_ok   (packet_ok),
		.table_valid (table_valid),
		.last_result (last_result)
	);

endmodule
`default_nettype wire

// ===== rtl/estl_checker.sv =====
// Port-level checks for the event sequence table loader, bound to the top level.
`default_nettype none
module estl_checker
	import estl_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [1:0]         result_kind,
	input wire logic [ADDR_W-1:0]  ram_address,
	input wire logic [GAP_W-1:0]   entry_gap,
	input wire logic [EVENT_W-1:0] entry_event,
	input wire logic               packet_ok,
	input wire logic               table_valid,
	input wire logic               last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_disable_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DISABLE |-> !table_valid && !packet_ok)
		else $error("disable command with table still valid");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATUS
		|-> ram_address == '0 && entry_gap == '0 && entry_event == '0)
		else $error("status request carries entry data");

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATUS && !packet_ok |-> last_result)
		else $error("failed packet status not last result of its word");

endmodule

bind event_sequence_table_loader estl_checker u_estl_checker (.*);
`default_nettype wire
